/* rtl/fsa_pkg.sv */
// Shared constants, types and helpers of the segment allocator.
`default_nettype none
package fsa_pkg;

    // Pool geometry
    localparam int MAX_SEGMENTS = 1024;
    localparam int ADDR_BITS    = 48;
    localparam int ID_W         = $clog2(MAX_SEGMENTS);
    localparam int CNT_W        = $clog2(MAX_SEGMENTS + 1);
    localparam int SIZE_W       = 33;
    localparam int BASE_W       = 48;
    localparam int OUT_ADDR_W   = 48;
    localparam int TOTAL_W      = 64;
    localparam int PROD_W       = ID_W + SIZE_W;
    localparam logic [63:0] ADDR_MASK =
        (ADDR_BITS >= 64) ? {64{1'b1}} : ((64'd1 << ADDR_BITS) - 64'd1);

    // Configuration port
    localparam int APB_AW    = 5;
    localparam int APB_DW    = 64;
    localparam int REG_IDX_W = 2;
    localparam logic [REG_IDX_W-1:0] REG_SEGMENT_COUNT = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_SEG_BYTES     = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_BASE_ADDRESS  = 2'd2;

    localparam logic [CNT_W-1:0]  RST_SEGMENT_COUNT = CNT_W'(1024);
    localparam logic [SIZE_W-1:0] RST_SEG_BYTES     = SIZE_W'(4194304);
    localparam logic [BASE_W-1:0] RST_BASE_ADDRESS  = '0;

    // Command queue between front and back
    localparam int CMDQ_DEPTH = 2;
    localparam int CMDQ_PTR_W = $clog2(CMDQ_DEPTH);
    localparam int CMDQ_CNT_W = $clog2(CMDQ_DEPTH + 1);

    // Request modes
    localparam logic MODE_ALLOC   = 1'b0;
    localparam logic MODE_RELEASE = 1'b1;

    typedef enum logic [1:0] {
        ST_OK          = 2'd0,
        ST_NO_FREE     = 2'd1,
        ST_NONE_IN_USE = 2'd2
    } t_status;

    typedef struct packed {
        logic [CNT_W-1:0]  segment_count;
        logic [SIZE_W-1:0] seg_bytes;
        logic [BASE_W-1:0] base_address;
    } t_cfg;

    typedef struct packed {
        logic            is_release;
        logic [ID_W-1:0] id;
    } t_cmd;

    // Step a returned-queue pointer with wrap at the pool depth
    function automatic logic [ID_W-1:0] next_ptr(input logic [ID_W-1:0] ptr);
        logic [ID_W-1:0] nxt;
        if (ptr == ID_W'(MAX_SEGMENTS - 1)) begin
            nxt = '0;
        end else begin
            nxt = ptr + 1'b1;
        end
        return nxt;
    endfunction

endpackage
`default_nettype wire

/* rtl/fsa_front.sv */
// Front end: configuration registers, request acceptance and classification.
`default_nettype none
module fsa_front (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 psel,
    input  wire                                 penable,
    input  wire                                 pwrite,
    input  wire [fsa_pkg::APB_AW-1:0]           paddr,
    input  wire [fsa_pkg::APB_DW-1:0]           pwdata,
    output logic [fsa_pkg::APB_DW-1:0]          prdata,
    output logic                                pready,
    input  wire                                 start,
    output logic                                busy,
    input  wire                                 i_mode,
    input  wire [fsa_pkg::ID_W-1:0]             i_release_id,
    input  wire                                 i_queue_full,
    output logic                                o_push,
    output fsa_pkg::t_cmd                       o_cmd,
    output fsa_pkg::t_cfg                       o_cfg
);
    import fsa_pkg::*;

    logic [CNT_W-1:0]     r_segment_count;
    logic [SIZE_W-1:0]    r_seg_bytes;
    logic [BASE_W-1:0]    r_base_address;
    logic                 cfg_we;
    logic [REG_IDX_W-1:0] reg_idx;

    assign pready  = 1'b1;
    assign reg_idx = paddr[APB_AW-1:3];
    assign cfg_we  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_segment_count <= RST_SEGMENT_COUNT;
            r_seg_bytes     <= RST_SEG_BYTES;
            r_base_address  <= RST_BASE_ADDRESS;
        end else if (cfg_we) begin
            case (reg_idx)
                REG_SEGMENT_COUNT: r_segment_count <= pwdata[CNT_W-1:0];
                REG_SEG_BYTES:     r_seg_bytes     <= pwdata[SIZE_W-1:0];
                REG_BASE_ADDRESS:  r_base_address  <= pwdata[BASE_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_SEGMENT_COUNT: prdata = APB_DW'(r_segment_count);
            REG_SEG_BYTES:     prdata = APB_DW'(r_seg_bytes);
            REG_BASE_ADDRESS:  prdata = APB_DW'(r_base_address);
            default:           prdata = '0;
        endcase
    end

    assign o_cfg.segment_count = r_segment_count;
    assign o_cfg.seg_bytes     = r_seg_bytes;
    assign o_cfg.base_address  = r_base_address;

    // Take a request whenever the command queue has room
    assign busy             = i_queue_full;
    assign o_push           = start && !busy;
    assign o_cmd.is_release = (i_mode == MODE_RELEASE);
    assign o_cmd.id         = i_release_id;

endmodule
`default_nettype wire

/* rtl/fsa_cmd_queue.sv */
// Short command queue that decouples the front end from the back end.
`default_nettype none
module fsa_cmd_queue (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    i_push,
    input  fsa_pkg::t_cmd          i_cmd,
    input  wire                    i_pop,
    output logic                   o_valid,
    output fsa_pkg::t_cmd          o_cmd,
    output logic                   o_full
);
    import fsa_pkg::*;

    t_cmd                  r_entry [CMDQ_DEPTH];
    logic [CMDQ_PTR_W-1:0] r_wr_ptr;
    logic [CMDQ_PTR_W-1:0] r_rd_ptr;
    logic [CMDQ_CNT_W-1:0] r_fill;
    logic                  do_pop;

    function automatic logic [CMDQ_PTR_W-1:0] step(input logic [CMDQ_PTR_W-1:0] p);
        logic [CMDQ_PTR_W-1:0] nxt;
        if (p == CMDQ_PTR_W'(CMDQ_DEPTH - 1)) begin
            nxt = '0;
        end else begin
            nxt = p + 1'b1;
        end
        return nxt;
    endfunction

    assign o_valid = (r_fill != '0);
    assign o_full  = (r_fill == CMDQ_CNT_W'(CMDQ_DEPTH));
    assign o_cmd   = r_entry[r_rd_ptr];
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= step(r_wr_ptr);
            end
            if (do_pop) begin
                r_rd_ptr <= step(r_rd_ptr);
            end
            if (i_push && !do_pop) begin
                r_fill <= r_fill + 1'b1;
            end else if (!i_push && do_pop) begin
                r_fill <= r_fill - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_entry[r_wr_ptr] <= i_cmd;
        end
    end

endmodule
`default_nettype wire

/* rtl/fsa_back.sv */
// Back end: free-list sequencer, returned-id memory and result register.
`default_nettype none
module fsa_back (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  fsa_pkg::t_cfg                    i_cfg,
    input  wire                              i_cmd_valid,
    input  fsa_pkg::t_cmd                    i_cmd,
    output logic                             o_pop,
    output logic                             o_result_valid,
    output logic [1:0]                       o_status,
    output logic [fsa_pkg::ID_W-1:0]         o_segment_id,
    output logic [fsa_pkg::OUT_ADDR_W-1:0]   o_start_address,
    output logic [fsa_pkg::CNT_W-1:0]        o_in_use,
    output logic [fsa_pkg::TOTAL_W-1:0]      o_bytes_allocated
);
    import fsa_pkg::*;

    typedef enum logic [3:0] {
        BK_IDLE = 4'b0001,
        BK_READ = 4'b0010,
        BK_MUL  = 4'b0100,
        BK_ADDR = 4'b1000
    } t_back_state;

    t_back_state r_state, n_state;
    logic [CNT_W-1:0]   r_fresh, n_fresh;
    logic [ID_W-1:0]    r_head, n_head;
    logic [ID_W-1:0]    r_tail, n_tail;
    logic [CNT_W-1:0]   r_fill, n_fill;
    logic [CNT_W-1:0]   r_used, n_used;
    logic [TOTAL_W-1:0] r_total, n_total;
    logic [ID_W-1:0]    r_id, n_id;
    logic [PROD_W-1:0]  r_prod, n_prod;

    logic                  r_out_valid, n_out_valid;
    t_status               r_out_status, n_out_status;
    logic [ID_W-1:0]       r_out_id, n_out_id;
    logic [OUT_ADDR_W-1:0] r_out_addr, n_out_addr;
    logic [CNT_W-1:0]      r_out_in_use, n_out_in_use;
    logic [TOTAL_W-1:0]    r_out_total, n_out_total;

    logic [ID_W-1:0] r_queue_mem [MAX_SEGMENTS];
    logic [ID_W-1:0] r_rd_data;
    logic            mem_we;
    logic            fresh_avail;
    logic [63:0]     addr_sum;

    assign fresh_avail = (r_fresh < i_cfg.segment_count) &&
                         (r_fresh < CNT_W'(MAX_SEGMENTS));
    assign addr_sum    = (64'(i_cfg.base_address) + 64'(r_prod)) & ADDR_MASK;

    always_comb begin
        n_state      = r_state;
        n_fresh      = r_fresh;
        n_head       = r_head;
        n_tail       = r_tail;
        n_fill       = r_fill;
        n_used       = r_used;
        n_total      = r_total;
        n_id         = r_id;
        n_prod       = r_prod;
        n_out_valid  = 1'b0;
        n_out_status = r_out_status;
        n_out_id     = r_out_id;
        n_out_addr   = r_out_addr;
        n_out_in_use = r_out_in_use;
        n_out_total  = r_out_total;
        mem_we       = 1'b0;
        o_pop        = 1'b0;
        case (r_state)
            BK_IDLE: begin
                if (i_cmd_valid) begin
                    o_pop = 1'b1;
                    if (i_cmd.is_release) begin
                        n_out_valid = 1'b1;
                        n_out_id    = '0;
                        n_out_addr  = '0;
                        n_out_total = r_total;
                        if (r_used == '0) begin
                            // drop the id: nothing is out
                            n_out_status = ST_NONE_IN_USE;
                            n_out_in_use = r_used;
                        end else begin
                            mem_we       = 1'b1;
                            n_tail       = next_ptr(r_tail);
                            n_fill       = r_fill + 1'b1;
                            n_used       = r_used - 1'b1;
                            n_out_status = ST_OK;
                            n_out_in_use = r_used - 1'b1;
                        end
                    end else if (fresh_avail) begin
                        n_id    = r_fresh[ID_W-1:0];
                        n_fresh = r_fresh + 1'b1;
                        n_state = BK_MUL;
                    end else if (r_fill != '0) begin
                        // memory read of the head entry is issued this cycle
                        n_head  = next_ptr(r_head);
                        n_fill  = r_fill - 1'b1;
                        n_state = BK_READ;
                    end else begin
                        n_out_valid  = 1'b1;
                        n_out_status = ST_NO_FREE;
                        n_out_id     = '0;
                        n_out_addr   = '0;
                        n_out_in_use = r_used;
                        n_out_total  = r_total;
                    end
                end
            end
            BK_READ: begin
                n_id    = r_rd_data;
                n_state = BK_MUL;
            end
            BK_MUL: begin
                n_prod  = PROD_W'(r_id) * PROD_W'(i_cfg.seg_bytes);
                n_used  = r_used + 1'b1;
                n_total = r_total + TOTAL_W'(i_cfg.seg_bytes);
                n_state = BK_ADDR;
            end
            BK_ADDR: begin
                n_out_valid  = 1'b1;
                n_out_status = ST_OK;
                n_out_id     = r_id;
                n_out_addr   = addr_sum[OUT_ADDR_W-1:0];
                n_out_in_use = r_used;
                n_out_total  = r_total;
                n_state      = BK_IDLE;
            end
            default: begin
                n_state = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BK_IDLE;
            r_fresh     <= '0;
            r_head      <= '0;
            r_tail      <= '0;
            r_fill      <= '0;
            r_used      <= '0;
            r_total     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_fresh     <= n_fresh;
            r_head      <= n_head;
            r_tail      <= n_tail;
            r_fill      <= n_fill;
            r_used      <= n_used;
            r_total     <= n_total;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_id         <= n_id;
        r_prod       <= n_prod;
        r_out_status <= n_out_status;
        r_out_id     <= n_out_id;
        r_out_addr   <= n_out_addr;
        r_out_in_use <= n_out_in_use;
        r_out_total  <= n_out_total;
    end

    // Returned-id memory: one write port, one registered read at the head
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_queue_mem[r_tail] <= i_cmd.id;
        end
        r_rd_data <= r_queue_mem[r_head];
    end

    assign o_result_valid    = r_out_valid;
    assign o_status          = r_out_status;
    assign o_segment_id      = r_out_id;
    assign o_start_address   = r_out_addr;
    assign o_in_use          = r_out_in_use;
    assign o_bytes_allocated = r_out_total;

endmodule
`default_nettype wire

/* rtl/fifo_segment_allocator_unit.sv */
// Top level of the FIFO segment allocator: front end, command queue, back end.
// A release or failed allocate passes the command queue and the result register; a fresh
// allocate also passes BK_MUL and BK_ADDR, a returned one BK_READ before them (memory read).
// The back end takes a new command only in BK_IDLE, so each command finishes before the next;
// busy rises only when the two-entry command queue is full.
// Reset (synchronous, i_rst_n low): defaults reloaded, list restarts at id 0, no clearing.
`default_nettype none
module fifo_segment_allocator_unit (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    // configuration port
    input  wire                              psel,
    input  wire                              penable,
    input  wire                              pwrite,
    input  wire [fsa_pkg::APB_AW-1:0]        paddr,
    input  wire [fsa_pkg::APB_DW-1:0]        pwdata,
    output logic [fsa_pkg::APB_DW-1:0]       prdata,
    output logic                             pready,
    // request side
    input  wire                              start,
    output logic                             busy,
    input  wire                              i_mode,
    input  wire [fsa_pkg::ID_W-1:0]          i_release_id,
    // result side
    output logic                             o_result_valid,
    output logic [1:0]                       o_status,
    output logic [fsa_pkg::ID_W-1:0]         o_segment_id,
    output logic [fsa_pkg::OUT_ADDR_W-1:0]   o_start_address,
    output logic [fsa_pkg::CNT_W-1:0]        o_in_use,
    output logic [fsa_pkg::TOTAL_W-1:0]      o_bytes_allocated
);
    import fsa_pkg::*;

    t_cfg cfg;
    t_cmd push_cmd;
    t_cmd head_cmd;
    logic push;
    logic pop;
    logic queue_full;
    logic queue_valid;

    // Front end: hold configuration, classify each accepted item as a command
    fsa_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .start        (start),
        .busy         (busy),
        .i_mode       (i_mode),
        .i_release_id (i_release_id),
        .i_queue_full (queue_full),
        .o_push       (push),
        .o_cmd        (push_cmd),
        .o_cfg        (cfg)
    );

    // Buffer commands so the front keeps taking items while the back works
    fsa_cmd_queue u_cmd_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .i_pop   (pop),
        .o_valid (queue_valid),
        .o_cmd   (head_cmd),
        .o_full  (queue_full)
    );

    // Back end: advance the free list and drive the result register
    fsa_back u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg             (cfg),
        .i_cmd_valid       (queue_valid),
        .i_cmd             (head_cmd),
        .o_pop             (pop),
        .o_result_valid    (o_result_valid),
        .o_status          (o_status),
        .o_segment_id      (o_segment_id),
        .o_start_address   (o_start_address),
        .o_in_use          (o_in_use),
        .o_bytes_allocated (o_bytes_allocated)
    );

endmodule
`default_nettype wire

/* rtl/fsa_checker.sv */
// Port-level checker for the segment allocator and its bind to the top level.
`default_nettype none
module fsa_checker (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              pready,
    input  wire                              busy,
    input  wire                              o_result_valid,
    input  wire [1:0]                        o_status,
    input  wire [fsa_pkg::ID_W-1:0]          o_segment_id,
    input  wire [fsa_pkg::OUT_ADDR_W-1:0]    o_start_address,
    input  wire [fsa_pkg::CNT_W-1:0]         o_in_use
);
    import fsa_pkg::*;

    // A failed request reports no segment
    a_fail_no_segment: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && (o_status != ST_OK)) |->
            ((o_segment_id == '0) && (o_start_address == '0)))
        else $error("failed request reported a segment");

    // A dropped release only happens with nothing in use
    a_drop_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && (o_status == ST_NONE_IN_USE)) |-> (o_in_use == '0))
        else $error("release dropped while segments in use");

    // Reset empties the command queue and the result register
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> (!busy && !o_result_valid))
        else $error("queue or result not cleared by reset");

    // The configuration port never inserts wait states
    a_pready_high: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pready)
        else $error("configuration port not ready");

endmodule

bind fifo_segment_allocator_unit fsa_checker u_fsa_checker (.*);
`default_nettype wire

/* tb/sv/fifo_segment_allocator_unit_test.sv */
// Self-checking testbench of the FIFO segment allocator: directed cases, then random traffic.
`timescale 1ns / 100ps
module fifo_segment_allocator_unit_test;
    import fsa_pkg::*;

    // Run control
    localparam int CLK_HALF       = 5;
    localparam int RESET_CYCLES   = 8;
    localparam int SETTLE_CYCLES  = 8;
    localparam int WATCHDOG_LIMIT = 2000;   // cycles with no accepted item, result or register access
    localparam int TRAFFIC_PHASES = 6;
    localparam int PHASE_ITEMS    = 242;    // about 1450 random items in all

    // One expected result of the allocator
    typedef struct packed {
        t_status                 status;
        logic [ID_W-1:0]         segment_id;
        logic [OUT_ADDR_W-1:0]   start_address;
        logic [CNT_W-1:0]        in_use;
        logic [TOTAL_W-1:0]      bytes_allocated;
    } t_alloc_result;

    // Block ports
    logic                    i_clk = 1'b0;
    logic                    i_rst_n;
    logic                    psel;
    logic                    penable;
    logic                    pwrite;
    logic [APB_AW-1:0]       paddr;
    logic [APB_DW-1:0]       pwdata;
    logic [APB_DW-1:0]       prdata;
    logic                    pready;
    logic                    start;
    logic                    busy;
    logic                    i_mode;
    logic [ID_W-1:0]         i_release_id;
    logic                    o_result_valid;
    logic [1:0]              o_status;
    logic [ID_W-1:0]         o_segment_id;
    logic [OUT_ADDR_W-1:0]   o_start_address;
    logic [CNT_W-1:0]        o_in_use;
    logic [TOTAL_W-1:0]      o_bytes_allocated;

    // Register copy held by the predictor
    logic [CNT_W-1:0]        cfg_seg_count;
    logic [SIZE_W-1:0]       cfg_seg_size;
    logic [BASE_W-1:0]       cfg_base;

    // Free-list state held by the predictor
    logic [CNT_W-1:0]        pool_fresh_next;
    logic [ID_W-1:0]         pool_returned [MAX_SEGMENTS];
    logic [ID_W-1:0]         pool_head;
    logic [ID_W-1:0]         pool_tail;
    logic [CNT_W-1:0]        pool_fill;
    logic [CNT_W-1:0]        pool_used;
    logic [TOTAL_W-1:0]      pool_bytes;

    // Results awaited from the block, oldest first
    t_alloc_result           pending_results [$];
    // Ids handed out and not yet given back, used to build well-formed releases
    logic [ID_W-1:0]         held_ids [$];

    int n_errors;
    int n_items;
    int n_results;
    int n_granted;
    int n_refused;
    int n_releases;
    int idle_cycles;

    fifo_segment_allocator_unit u_top (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .psel              (psel),
        .penable           (penable),
        .pwrite            (pwrite),
        .paddr             (paddr),
        .pwdata            (pwdata),
        .prdata            (prdata),
        .pready            (pready),
        .start             (start),
        .busy              (busy),
        .i_mode            (i_mode),
        .i_release_id      (i_release_id),
        .o_result_valid    (o_result_valid),
        .o_status          (o_status),
        .o_segment_id      (o_segment_id),
        .o_start_address   (o_start_address),
        .o_in_use          (o_in_use),
        .o_bytes_allocated (o_bytes_allocated)
    );

    always begin
        #CLK_HALF i_clk = 1'b1;
        #CLK_HALF i_clk = 1'b0;
    end

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    // Advance the free-list copy by one request and return what the block must answer.
    function automatic t_alloc_result predict_request(input logic mode,
                                                      input logic [ID_W-1:0] rel_id);
        t_alloc_result   res;
        logic [CNT_W-1:0] fresh_limit;
        logic [ID_W-1:0] id;
        logic            granted;
        logic [63:0]     addr_full;
        res         = '0;
        res.status  = ST_OK;
        granted     = 1'b0;
        id          = '0;
        // counts above the pool depth are clipped to the pool depth
        fresh_limit = (cfg_seg_count < CNT_W'(MAX_SEGMENTS)) ? cfg_seg_count
                                                             : CNT_W'(MAX_SEGMENTS);
        if (mode == MODE_ALLOC) begin
            // drain never-issued ids first, then the returned ids in queue order
            if (pool_fresh_next < fresh_limit) begin
                id              = pool_fresh_next[ID_W-1:0];
                pool_fresh_next = pool_fresh_next + 1'b1;
                granted         = 1'b1;
            end else if (pool_fill != '0) begin
                id        = pool_returned[pool_head];
                pool_head = pool_head + 1'b1;   // pointer width wraps at the pool depth
                pool_fill = pool_fill - 1'b1;
                granted   = 1'b1;
            end
            if (granted) begin
                pool_used         = pool_used + 1'b1;
                pool_bytes        = pool_bytes + TOTAL_W'(cfg_seg_size);
                addr_full         = 64'(cfg_base) + 64'(id) * 64'(cfg_seg_size);
                res.segment_id    = id;
                res.start_address = OUT_ADDR_W'(addr_full & ADDR_MASK);
            end else begin
                res.status = ST_NO_FREE;
            end
        end else begin
            // nothing in use: drop the id; otherwise queue it, checked or not
            if (pool_used == '0) begin
                res.status = ST_NONE_IN_USE;
            end else begin
                pool_returned[pool_tail] = rel_id;
                pool_tail = pool_tail + 1'b1;
                pool_fill = pool_fill + 1'b1;
                pool_used = pool_used - 1'b1;
            end
        end
        res.in_use          = pool_used;
        res.bytes_allocated = pool_bytes;
        return res;
    endfunction

    // Offer one item, hold it until the block takes it, then record its expected result.
    // Called and left just after a rising edge; start stays high for a following item.
    task automatic send_item(input logic mode, input logic [ID_W-1:0] rel_id,
                             input int idle_pct);
        t_alloc_result res;
        int gap;
        gap = 0;
        if (idle_pct > 0) begin
            while ($urandom_range(0, 99) < idle_pct) gap++;
        end
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start        <= 1'b1;
        i_mode       <= mode;
        i_release_id <= rel_id;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        res = predict_request(mode, rel_id);
        pending_results.push_back(res);
        n_items++;
        if (mode == MODE_RELEASE) begin
            n_releases++;
        end else if (res.status == ST_OK) begin
            n_granted++;
            held_ids.push_back(res.segment_id);
        end else begin
            n_refused++;
        end
    endtask

    // Drop start and wait until every result is in, plus the block's latency.
    task automatic settle_pool();
        start <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Write one register over APB, read it back, and update the register copy.
    task automatic reg_write_check(input logic [REG_IDX_W-1:0] idx, input logic [63:0] value);
        logic [63:0] expected_rd;
        logic [63:0] rd;
        // setup, then access; the write lands at the edge that ends the access
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_AW'({idx, 3'b000});
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        case (idx)
            REG_SEGMENT_COUNT: cfg_seg_count = value[CNT_W-1:0];
            REG_SEG_BYTES:     cfg_seg_size  = value[SIZE_W-1:0];
            default:           cfg_base      = value[BASE_W-1:0];
        endcase
        case (idx)
            REG_SEGMENT_COUNT: expected_rd = 64'(cfg_seg_count);
            REG_SEG_BYTES:     expected_rd = 64'(cfg_seg_size);
            default:           expected_rd = 64'(cfg_base);
        endcase
        // read back on the same select
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        rd = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
        if (rd !== expected_rd) begin
            $error("register %0d readback mismatch: expected 'h%0h, actual 'h%0h",
                   idx, expected_rd, rd);
            n_errors++;
        end
    endtask

    // Compare each strobed result with the oldest expectation.
    always @(posedge i_clk) begin : result_check
        t_alloc_result exp_res;
        if (i_rst_n && o_result_valid) begin
            n_results++;
            if (pending_results.size() == 0) begin
                $error("result strobed with no expectation pending");
                n_errors++;
            end else begin
                exp_res = pending_results.pop_front();
                if (o_status !== exp_res.status) begin
                    $error("status mismatch: expected %0d, actual %0d",
                           exp_res.status, o_status);
                    n_errors++;
                end
                if (o_segment_id !== exp_res.segment_id) begin
                    $error("segment_id mismatch: expected %0d, actual %0d",
                           exp_res.segment_id, o_segment_id);
                    n_errors++;
                end
                if (o_start_address !== exp_res.start_address) begin
                    $error("start_address mismatch: expected 'h%0h, actual 'h%0h",
                           exp_res.start_address, o_start_address);
                    n_errors++;
                end
                if (o_in_use !== exp_res.in_use) begin
                    $error("in_use mismatch: expected %0d, actual %0d",
                           exp_res.in_use, o_in_use);
                    n_errors++;
                end
                if (o_bytes_allocated !== exp_res.bytes_allocated) begin
                    $error("bytes_allocated mismatch: expected 'h%0h, actual 'h%0h",
                           exp_res.bytes_allocated, o_bytes_allocated);
                    n_errors++;
                end
            end
        end
    end

    // End the run if nothing moves on either side for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_result_valid || (psel && penable)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("simulation failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Release right after reset: nothing is in use, so both ids are dropped.
    task automatic test_release_none_in_use();
        send_item(MODE_RELEASE, ID_W'(0), 0);
        send_item(MODE_RELEASE, ID_W'(MAX_SEGMENTS - 1), 0);
        settle_pool();
    endtask

    // Fresh ids come out in order with the reset size and base.
    task automatic test_fresh_order();
        repeat (3) send_item(MODE_ALLOC, '0, 0);
        settle_pool();
    endtask

    // Give back an id never issued and one id twice; they return in queue order,
    // then the list runs empty.
    task automatic test_unchecked_release();
        send_item(MODE_RELEASE, ID_W'(MAX_SEGMENTS - 1), 0);
        send_item(MODE_RELEASE, ID_W'(1), 0);
        send_item(MODE_RELEASE, ID_W'(1), 0);
        send_item(MODE_RELEASE, ID_W'(5), 0);
        settle_pool();
        reg_write_check(REG_SEGMENT_COUNT, 64'd3);
        repeat (4) send_item(MODE_ALLOC, '0, 0);
        settle_pool();
    endtask

    // Zero size keeps every address at the base; the widest size wraps the address.
    task automatic test_size_extremes();
        reg_write_check(REG_SEGMENT_COUNT, 64'd5);
        reg_write_check(REG_SEG_BYTES, 64'd0);
        reg_write_check(REG_BASE_ADDRESS, 64'(ADDR_MASK) & 64'hFFFF_FFFF_FFFF);
        send_item(MODE_ALLOC, '0, 0);
        settle_pool();
        reg_write_check(REG_SEG_BYTES, 64'h1_FFFF_FFFF);
        send_item(MODE_ALLOC, '0, 0);
        send_item(MODE_RELEASE, ID_W'(4), 0);
        send_item(MODE_RELEASE, ID_W'(3), 0);
        settle_pool();
    endtask

    // A count of zero serves only returned ids; a count above the depth reopens fresh ids.
    task automatic test_count_extremes();
        reg_write_check(REG_SEGMENT_COUNT, 64'd0);
        repeat (3) send_item(MODE_ALLOC, '0, 0);
        settle_pool();
        reg_write_check(REG_SEGMENT_COUNT, 64'd2047);
        send_item(MODE_ALLOC, '0, 0);
        settle_pool();
    endtask

    // Random traffic in bursts: fills, drains of held ids, mixes and noise.
    task automatic test_random_traffic(input int phase_items, input int idle_pct);
        int sent;
        int kind;
        int len;
        int pct;
        int pick;
        logic mode;
        logic [ID_W-1:0] rel_id;
        sent = 0;
        while (sent < phase_items) begin
            kind = $urandom_range(0, 9);
            len  = $urandom_range(1, 12);
            // leave some bursts without any idling
            pct  = ($urandom_range(0, 3) == 0) ? 0 : idle_pct;
            repeat (len) begin
                case (kind)
                    0, 1, 2, 3: mode = MODE_ALLOC;
                    4, 5, 6:    mode = MODE_RELEASE;
                    default:    mode = logic'($urandom_range(0, 1));
                endcase
                rel_id = ID_W'($urandom_range(0, MAX_SEGMENTS - 1));
                // well-formed releases give back a held id; noise keeps the random one
                if (mode == MODE_RELEASE && kind != 9 && held_ids.size() != 0) begin
                    pick   = $urandom_range(0, held_ids.size() - 1);
                    rel_id = held_ids[pick];
                    held_ids.delete(pick);
                end
                send_item(mode, rel_id, pct);
                sent++;
            end
        end
        settle_pool();
    endtask

    initial begin
        logic [63:0] cfg_count_val;
        logic [63:0] cfg_size_val;
        logic [63:0] cfg_base_val;
        int idle_pct;

        // Drive every input to a known value and hold reset.
        i_rst_n      <= 1'b0;
        psel         <= 1'b0;
        penable      <= 1'b0;
        pwrite       <= 1'b0;
        paddr        <= '0;
        pwdata       <= '0;
        start        <= 1'b0;
        i_mode       <= MODE_ALLOC;
        i_release_id <= '0;
        n_errors     = 0;
        n_items      = 0;
        n_results    = 0;
        n_granted    = 0;
        n_refused    = 0;
        n_releases   = 0;

        // Predictor starts from the reset state of the block.
        cfg_seg_count   = RST_SEGMENT_COUNT;
        cfg_seg_size    = RST_SEG_BYTES;
        cfg_base        = RST_BASE_ADDRESS;
        pool_fresh_next = '0;
        pool_head       = '0;
        pool_tail       = '0;
        pool_fill       = '0;
        pool_used       = '0;
        pool_bytes      = '0;

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_release_none_in_use();
        test_fresh_order();
        test_unchecked_release();
        test_size_extremes();
        test_count_extremes();

        // Each phase sets new registers, extremes included, and a sender idle rate.
        for (int phase = 0; phase < TRAFFIC_PHASES; phase++) begin
            case (phase)
                0: begin
                    cfg_count_val = 64'($urandom_range(4, 16));
                    cfg_size_val  = 64'($urandom_range(1, 4096));
                    cfg_base_val  = rand64() & 64'hFFFF_FFFF_FFFF;
                end
                1: begin
                    cfg_count_val = 64'(MAX_SEGMENTS);
                    cfg_size_val  = 64'h1_0000_0000;
                    cfg_base_val  = 64'd0;
                end
                2: begin
                    cfg_count_val = 64'($urandom_range(1, 8));
                    cfg_size_val  = rand64() & 64'h1_FFFF_FFFF;
                    cfg_base_val  = 64'hFFFF_FFFF_FFFF;
                end
                3: begin
                    cfg_count_val = 64'd2047;
                    cfg_size_val  = 64'd1;
                    cfg_base_val  = rand64() & 64'hFFFF_FFFF_FFFF;
                end
                4: begin
                    cfg_count_val = 64'd1;
                    cfg_size_val  = 64'd0;
                    cfg_base_val  = rand64() & 64'hFFFF_FFFF_FFFF;
                end
                default: begin
                    cfg_count_val = 64'($urandom_range(1, MAX_SEGMENTS));
                    cfg_size_val  = rand64() & 64'h1_FFFF_FFFF;
                    cfg_base_val  = rand64() & 64'hFFFF_FFFF_FFFF;
                end
            endcase
            reg_write_check(REG_SEGMENT_COUNT, cfg_count_val);
            reg_write_check(REG_SEG_BYTES, cfg_size_val);
            reg_write_check(REG_BASE_ADDRESS, cfg_base_val);
            idle_pct = (phase < 2) ? 22 : (phase < 4) ? 57 : 0;
            test_random_traffic(PHASE_ITEMS, idle_pct);
        end

        // Wait out the last results; the watchdog bounds this.
        settle_pool();

        $display("covered %0d requests: %0d granted, %0d refused on an empty list, %0d releases",
                 n_items, n_granted, n_refused, n_releases);
        $display("checked %0d results over %0d register settings and sender idle rates 22/57/0",
                 n_results, TRAFFIC_PHASES + 4);
        if (n_errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
